[hdl/bfra_pkg.sv]
// bfra_pkg: types, codes and widths shared by the best-fit range allocator.
// No dependencies.
`timescale 1ns / 1ps
package bfra_pkg;

	localparam int unsigned DEF_SLOT_CAPACITY = 1024;
	localparam int unsigned DEF_MAX_EXTENTS = 64;
	localparam int unsigned DEF_TOTAL_COUNT = 1024;

	localparam int unsigned CNT_W = 11;
	localparam int unsigned START_W = 10;
	localparam int unsigned TOTAL_W = 11;
	// internal widths cover the largest pool and table
	localparam int unsigned B_W = 16;
	localparam int unsigned L_W = 17;
	localparam int unsigned X_W = 11;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ZERO = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_REMOVE,
		OP_INSERT,
		OP_JOIN,
		OP_RESTART
	} op_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic func;
		logic [CNT_W-1:0] count;
		logic [START_W-1:0] start_req;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [START_W-1:0] first_slot;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [B_W-1:0] first;
		logic [L_W-1:0] len;
	} ext_t;

	typedef struct packed {
		op_t op;
		logic [X_W-1:0] idx;
		logic [B_W-1:0] first;
		logic [L_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic func;
		logic [L_W-1:0] count;
		logic [L_W-1:0] start;
		logic found;
		logic [L_W-1:0] best_left;
		logic [X_W-1:0] best_idx;
		logic [B_W-1:0] best_first;
		logic have_prev;
		logic [B_W-1:0] prev_first;
		logic [L_W-1:0] prev_len;
		logic pos_found;
		logic [X_W-1:0] pos;
		logic have_next;
		logic [B_W-1:0] next_first;
		logic [L_W-1:0] next_len;
	} tok_t;

endpackage

[hdl/bfra_cell.sv]
// bfra_cell: one free-extent cell of the sorted chain; folds its extent into
// the passing search token and applies table updates. Uses bfra_pkg.
`timescale 1ns / 1ps
module bfra_cell import bfra_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input tok_t tok_in,
	output tok_t tok_out,
	input cmd_t cmd,
	input ext_t left,
	input ext_t right,
	output ext_t cur
);

	localparam logic [X_W-1:0] MY_IDX = X_W'(IDX);
	localparam logic [X_W-1:0] MY_IDX_P1 = X_W'(IDX + 1);

	logic valid_q;
	logic [B_W-1:0] first_q;
	logic [L_W-1:0] len_q;
	logic act_q;
	tok_t tok_q;
	tok_t tok_d;
	logic [L_W-1:0] left_over;

	assign cur = '{valid: valid_q, first: first_q, len: len_q};

	always_comb begin
		tok_d = tok_in;
		left_over = len_q - tok_in.count;
		if (tok_in.func == FUNC_ALLOC) begin
			if (valid_q && tok_in.count <= len_q) begin
				if (!tok_in.found || left_over < tok_in.best_left) begin
					tok_d.found = 1'b1;
					tok_d.best_left = left_over;
					tok_d.best_idx = MY_IDX;
					tok_d.best_first = first_q;
				end
			end
		end else begin
			if (valid_q && L_W'(first_q) <= tok_in.start) begin
				tok_d.have_prev = 1'b1;
				tok_d.prev_first = first_q;
				tok_d.prev_len = len_q;
			end else if (!tok_in.pos_found) begin
				tok_d.pos_found = 1'b1;
				tok_d.pos = MY_IDX;
				tok_d.have_next = valid_q;
				tok_d.next_first = first_q;
				tok_d.next_len = len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.act;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.act = act_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_REMOVE, OP_JOIN: begin
					if (MY_IDX >= cmd.idx) valid_q <= right.valid;
				end
				OP_INSERT: begin
					if (MY_IDX > cmd.idx) valid_q <= left.valid;
					else if (MY_IDX == cmd.idx) valid_q <= 1'b1;
				end
				OP_RESTART: begin
					valid_q <= (IDX == 0) ? (cmd.len != '0) : 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SET: begin
				if (MY_IDX == cmd.idx) begin
					first_q <= cmd.first;
					len_q <= cmd.len;
				end
			end
			OP_REMOVE: begin
				if (MY_IDX >= cmd.idx) begin
					first_q <= right.first;
					len_q <= right.len;
				end
			end
			OP_JOIN: begin
				if (MY_IDX_P1 == cmd.idx) begin
					len_q <= cmd.len;
				end else if (MY_IDX >= cmd.idx) begin
					first_q <= right.first;
					len_q <= right.len;
				end
			end
			OP_INSERT: begin
				if (MY_IDX > cmd.idx) begin
					first_q <= left.first;
					len_q <= left.len;
				end else if (MY_IDX == cmd.idx) begin
					first_q <= cmd.first;
					len_q <= cmd.len;
				end
			end
			OP_RESTART: begin
				if (IDX == 0) begin
					first_q <= '0;
					len_q <= cmd.len;
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/bfra_ctrl.sv]
// bfra_ctrl: request sequencer, live-length memory, decision after the chain
// scan and the result register. Uses bfra_pkg.
`timescale 1ns / 1ps
module bfra_ctrl import bfra_pkg::*; #(
	parameter int unsigned SLOT_CAPACITY = DEF_SLOT_CAPACITY,
	parameter int unsigned MAX_EXTENTS = DEF_MAX_EXTENTS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_we,
	input logic [TOTAL_W-1:0] cfg_data,
	output tok_t tok_head,
	input tok_t tok_tail,
	output cmd_t cmd
);

	localparam int unsigned AW = (SLOT_CAPACITY > 2) ? $clog2(SLOT_CAPACITY) : 1;
	localparam logic [L_W-1:0] CAP = L_W'(SLOT_CAPACITY);
	localparam logic [L_W-1:0] RST_LEN =
		(SLOT_CAPACITY < DEF_TOTAL_COUNT) ? L_W'(SLOT_CAPACITY) : L_W'(DEF_TOTAL_COUNT);
	localparam logic [X_W-1:0] MAXX = X_W'(MAX_EXTENTS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_CAPACITY - 1);
	localparam cmd_t CMD_IDLE = '{op: OP_NONE, idx: '0, first: '0, len: '0};

	logic [CNT_W-1:0] live_mem [SLOT_CAPACITY];
	logic [CNT_W-1:0] rd_q;

	state_t state_q, state_d;
	logic [X_W-1:0] used_q;
	logic [AW-1:0] clr_q;
	cmd_t cmd_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	req_t req_q;
	rsp_t pend_rsp_q;
	cmd_t pend_cmd_q;
	logic pend_we_q;
	logic [AW-1:0] pend_addr_q;
	logic [CNT_W-1:0] pend_wd_q;
	logic [X_W-1:0] pend_used_q;

	logic accept, fire;
	logic [31:0] start_ext;
	logic [AW-1:0] start_addr;
	logic start_ok;
	logic [L_W-1:0] cfg_len;

	rsp_t dec_rsp;
	cmd_t dec_cmd;
	logic dec_we;
	logic [AW-1:0] dec_addr;
	logic [CNT_W-1:0] dec_wd;
	logic [X_W-1:0] dec_used;
	logic [L_W-1:0] flen, fstart, prev_end;
	logic [X_W-1:0] pos;
	logic join_prev, join_next;
	logic [31:0] best_ext;

	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [CNT_W-1:0] mem_wd;

	assign accept = req_valid && !req_stall;
	assign fire = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign start_ext = 32'(req.start_req);
	assign start_addr = start_ext[AW-1:0];
	assign start_ok = L_W'(req.start_req) < CAP;
	assign cfg_len = (L_W'(cfg_data) > CAP) ? CAP : L_W'(cfg_data);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign cmd = cmd_q;

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		tok_head = '0;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				// hold off while the last table update is still being applied
				if (cmd_q.op == OP_NONE) begin
					req_stall = 1'b0;
					if (req_valid) begin
						if (req.func == FUNC_ALLOC && req.count == '0) begin
							state_d = S_FINISH;
						end else if (req.func == FUNC_FREE && !start_ok) begin
							state_d = S_FINISH;
						end else begin
							state_d = S_SCAN;
							tok_head.act = 1'b1;
							tok_head.func = req.func;
							tok_head.count = L_W'(req.count);
							tok_head.start = L_W'(req.start_req);
						end
					end
				end
			end
			S_SCAN: begin
				if (tok_tail.act) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	// decision once the token leaves the chain
	always_comb begin
		dec_rsp = '{status: ST_OK, first_slot: '0};
		dec_cmd = CMD_IDLE;
		dec_we = 1'b0;
		dec_addr = '0;
		dec_wd = '0;
		dec_used = used_q;
		flen = L_W'(rd_q);
		fstart = L_W'(req_q.start_req);
		prev_end = L_W'(tok_tail.prev_first) + tok_tail.prev_len;
		pos = tok_tail.pos_found ? tok_tail.pos : used_q;
		join_prev = tok_tail.have_prev && prev_end == fstart;
		join_next = tok_tail.have_next && (fstart + flen) == L_W'(tok_tail.next_first);
		best_ext = 32'(tok_tail.best_first);
		if (req_q.func == FUNC_ALLOC) begin
			if (!tok_tail.found) begin
				dec_rsp.status = ST_NOSPACE;
			end else begin
				dec_rsp.first_slot = tok_tail.best_first[START_W-1:0];
				dec_we = 1'b1;
				dec_addr = best_ext[AW-1:0];
				dec_wd = req_q.count;
				dec_cmd.idx = tok_tail.best_idx;
				if (tok_tail.best_left != '0) begin
					dec_cmd.op = OP_SET;
					dec_cmd.first = tok_tail.best_first + B_W'(req_q.count);
					dec_cmd.len = tok_tail.best_left;
				end else begin
					dec_cmd.op = OP_REMOVE;
					dec_used = used_q - 1'b1;
				end
			end
		end else if (rd_q == '0) begin
			dec_rsp.status = ST_NOTALLOC;
		end else begin
			dec_we = 1'b1;
			dec_addr = pend_addr_q;
			if (join_prev && join_next) begin
				dec_cmd.op = OP_JOIN;
				dec_cmd.idx = pos;
				dec_cmd.len = tok_tail.prev_len + flen + tok_tail.next_len;
				dec_used = used_q - 1'b1;
			end else if (join_prev) begin
				dec_cmd.op = OP_SET;
				dec_cmd.idx = pos - 1'b1;
				dec_cmd.first = tok_tail.prev_first;
				dec_cmd.len = tok_tail.prev_len + flen;
			end else if (join_next) begin
				dec_cmd.op = OP_SET;
				dec_cmd.idx = pos;
				dec_cmd.first = B_W'(req_q.start_req);
				dec_cmd.len = tok_tail.next_len + flen;
			end else if (used_q >= MAXX) begin
				dec_rsp.status = ST_FULL;
				dec_we = 1'b0;
			end else begin
				dec_cmd.op = OP_INSERT;
				dec_cmd.idx = pos;
				dec_cmd.first = B_W'(req_q.start_req);
				dec_cmd.len = flen;
				dec_used = used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			used_q <= X_W'(1);
			clr_q <= '0;
			cmd_q <= '{op: OP_RESTART, idx: '0, first: '0, len: RST_LEN};
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmd_q <= CMD_IDLE;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (fire) begin
				rsp_valid_q <= 1'b1;
				cmd_q <= pend_cmd_q;
				used_q <= pend_used_q;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				clr_q <= '0;
				used_q <= (cfg_len != '0) ? X_W'(1) : '0;
				cmd_q <= '{op: OP_RESTART, idx: '0, first: '0, len: cfg_len};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			rd_q <= live_mem[start_addr];
			pend_addr_q <= start_addr;
			pend_cmd_q <= CMD_IDLE;
			pend_we_q <= 1'b0;
			pend_wd_q <= '0;
			pend_used_q <= used_q;
			pend_rsp_q <= '{status: (req.func == FUNC_ALLOC) ? ST_ZERO : ST_NOTALLOC,
				first_slot: '0};
		end
		if (state_q == S_SCAN && tok_tail.act) begin
			pend_rsp_q <= dec_rsp;
			pend_cmd_q <= dec_cmd;
			pend_we_q <= dec_we;
			pend_addr_q <= dec_addr;
			pend_wd_q <= dec_wd;
			pend_used_q <= dec_used;
		end
		if (fire) rsp_q <= pend_rsp_q;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (fire && pend_we_q) begin
			mem_we = 1'b1;
			mem_wa = pend_addr_q;
			mem_wd = pend_wd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) live_mem[mem_wa] <= mem_wd;
	end

endmodule

[hdl/best_fit_range_allocator.sv]
// best_fit_range_allocator: top level; chain of extent cells and controller.
// Uses bfra_pkg, bfra_cell, bfra_ctrl.
//
//  channel | signals                   | transfer when
//  --------+---------------------------+-----------------------------
//  request | req_valid, req_stall, req | req_valid && !req_stall
//  result  | rsp_valid, rsp_stall, rsp | rsp_valid && !rsp_stall
//  config  | cfg_we, cfg_data          | cfg_we
//
// Allocate and free: the token walks the chain one cell a cycle, the decision
// is registered once it leaves the chain, and the result and the table update
// are committed together once the result register is free; the next request
// is taken once the table update has been applied. Zero count and out-of-range
// free skip the chain and go straight to the result.
// After reset or a config write the live-length memory is cleared, one slot a
// cycle; req_stall stays high meanwhile.
// One request at a time; a finished result may wait in the output register.
`timescale 1ns / 1ps
module best_fit_range_allocator import bfra_pkg::*; #(
	parameter int unsigned SLOT_CAPACITY = DEF_SLOT_CAPACITY,
	parameter int unsigned MAX_EXTENTS = DEF_MAX_EXTENTS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_we,
	input logic [TOTAL_W-1:0] cfg_data
);

	tok_t tok [MAX_EXTENTS+1];
	ext_t cur [MAX_EXTENTS];
	cmd_t cmd;

	bfra_ctrl #(
		.SLOT_CAPACITY(SLOT_CAPACITY),
		.MAX_EXTENTS(MAX_EXTENTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.tok_head(tok[0]),
		.tok_tail(tok[MAX_EXTENTS]),
		.cmd(cmd)
	);

	for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
		ext_t left_n, right_n;
		if (i == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = cur[i-1];
		end
		if (i == MAX_EXTENTS - 1) begin : g_last
			assign right_n = '0;
		end else begin : g_mid_r
			assign right_n = cur[i+1];
		end
		bfra_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(tok[i]),
			.tok_out(tok[i+1]),
			.cmd(cmd),
			.left(left_n),
			.right(right_n),
			.cur(cur[i])
		);
	end

endmodule

[hdl/bfra_chk.sv]
// bfra_chk: port-level checks for best_fit_range_allocator, bound to the top.
// Uses bfra_pkg.
`timescale 1ns / 1ps
module bfra_chk import bfra_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp,
	input logic cfg_we
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> req_stall)
		else $error("request taken during pool clear");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.first_slot == '0)
		else $error("failed request carries a slot");

endmodule

bind best_fit_range_allocator bfra_chk u_bfra_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp),
	.cfg_we(cfg_we)
);
